// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the pulse pair asymmetry core
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent true on the same edge
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/tppa_pkg.sv =====
// shared types and constants of the triggered pulse pair asymmetry core
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package tppa_pkg;

    // sample and window sizing
    localparam int SAMPLE_BITS = 32;
    localparam int MAX_WINDOW  = 1023;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int ACC_W       = SAMPLE_BITS + CNT_W;
    localparam int DIFF_W      = ACC_W + 1;

    // fixed port widths
    localparam int IN_W   = 32;
    localparam int IDX_W  = 20;
    localparam int RAW_W  = 43;
    localparam int OUT_W  = 64;
    localparam int GAIN_W = 32;
    localparam int SHF_W  = 6;
    localparam int THR_W  = 31;
    localparam int WIN_W  = 10;

    // scaling datapath: magnitude split into a 32 bit low part and the rest
    localparam int MAG_W  = (DIFF_W > 32) ? DIFF_W : 33;
    localparam int HI_W   = MAG_W - 32;
    localparam int PROD_W = MAG_W + GAIN_W;

    // pair queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_DELAY     = 3'd1,
        CFG_LENGTH    = 3'd2,
        CFG_GAIN      = 3'd3,
        CFG_SHIFT     = 3'd4
    } t_cfg_reg;

    localparam logic [THR_W-1:0]  RST_THRESHOLD = THR_W'(95000000);
    localparam logic [WIN_W-1:0]  RST_DELAY     = WIN_W'(400);
    localparam logic [WIN_W-1:0]  RST_LENGTH    = WIN_W'(600);
    localparam logic [GAIN_W-1:0] RST_GAIN      = GAIN_W'(1);
    localparam logic [SHF_W-1:0]  RST_SHIFT     = SHF_W'(0);

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [WIN_W-1:0]  delay;
        logic [WIN_W-1:0]  length;
        logic [GAIN_W-1:0] gain;
        logic [SHF_W-1:0]  shift;
    } t_cfg;

    // one completed pulse pair
    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DIFF_W-1:0] diff;
    } t_pair_word;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_status;

endpackage

// ===== rtl/tppa_front.sv =====
// front end: trigger search, delay, boxcar integration and pair differencing
// depends on tppa_pkg
`timescale 1ns / 1ps

module tppa_front
    import tppa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_accept,
    input  logic [IN_W-1:0]        i_trigger_sample,
    input  logic [IN_W-1:0]        i_signal_sample,
    output logic                   o_push,
    output t_pair_word             o_push_word
);

    logic [CNT_W-1:0]        r_holdoff, n_holdoff;
    logic [CNT_W-1:0]        r_pend, n_pend;
    logic [CNT_W-1:0]        r_integ, n_integ;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W-1:0] r_first, n_first;
    logic                    r_phase, n_phase;
    logic [IDX_W-1:0]        r_pair, n_pair;

    logic signed [SAMPLE_BITS-1:0] trig;
    logic signed [SAMPLE_BITS-1:0] sig;
    logic [SAMPLE_BITS-1:0]        tmag;
    logic [31:0]                   w32;
    logic [31:0]                   d32;
    logic [CNT_W-1:0]              eff_w;
    logic [CNT_W-1:0]              eff_d;
    logic                          fire;
    logic                          start;
    logic [CNT_W-1:0]              integ_base;
    logic signed [ACC_W-1:0]       acc_base;
    logic signed [ACC_W-1:0]       acc_sum;
    logic                          done;

    always_comb begin
        trig = signed'(i_trigger_sample[SAMPLE_BITS-1:0]);
        sig  = signed'(i_signal_sample[SAMPLE_BITS-1:0]);
        tmag = trig[SAMPLE_BITS-1] ? SAMPLE_BITS'(-trig) : SAMPLE_BITS'(trig);

        // effective window and clamped delay
        w32 = 32'(i_cfg.length);
        if (w32 == 32'd0) begin
            w32 = 32'd1;
        end else if (w32 > 32'(MAX_WINDOW)) begin
            w32 = 32'(MAX_WINDOW);
        end
        d32   = (32'(i_cfg.delay) < w32) ? 32'(i_cfg.delay) : w32;
        eff_w = w32[CNT_W-1:0];
        eff_d = d32[CNT_W-1:0];

        fire = (r_holdoff == '0) && (32'(tmag) > 32'(i_cfg.threshold));

        n_pend = (r_pend != '0) ? r_pend - CNT_W'(1) : '0;
        start  = (r_pend == CNT_W'(1));
        if (fire && eff_d != '0) begin
            n_pend = eff_d;
        end
        if (fire && eff_d == '0) begin
            start = 1'b1;
        end

        if (r_holdoff != '0) begin
            n_holdoff = r_holdoff - CNT_W'(1);
        end else if (fire) begin
            n_holdoff = eff_w - CNT_W'(1);
        end else begin
            n_holdoff = '0;
        end

        // a new start drops any unfinished sum
        integ_base = start ? eff_w : r_integ;
        acc_base   = start ? '0 : r_acc;
        acc_sum    = acc_base + ACC_W'(sig);

        n_integ = integ_base;
        n_acc   = acc_base;
        done    = 1'b0;
        if (integ_base != '0) begin
            n_integ = integ_base - CNT_W'(1);
            n_acc   = acc_sum;
            done    = (integ_base == CNT_W'(1));
        end

        n_first = r_first;
        n_phase = r_phase;
        n_pair  = r_pair;
        o_push  = 1'b0;
        o_push_word.idx  = r_pair;
        o_push_word.diff = DIFF_W'(r_first) - DIFF_W'(acc_sum);
        if (done) begin
            if (!r_phase) begin
                n_first = acc_sum;
                n_phase = 1'b1;
            end else begin
                o_push  = i_accept;
                n_pair  = r_pair + IDX_W'(1);
                n_phase = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff <= '0;
            r_pend    <= '0;
            r_integ   <= '0;
            r_acc     <= '0;
            r_first   <= '0;
            r_phase   <= 1'b0;
            r_pair    <= '0;
        end else if (i_accept) begin
            r_holdoff <= n_holdoff;
            r_pend    <= n_pend;
            r_integ   <= n_integ;
            r_acc     <= n_acc;
            r_first   <= n_first;
            r_phase   <= n_phase;
            r_pair    <= n_pair;
        end
    end

endmodule

// ===== rtl/tppa_fifo.sv =====
// short queue of completed pairs between front and back
// depends on tppa_pkg
`timescale 1ns / 1ps

module tppa_fifo
    import tppa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_pair_word i_push_word,
    input  logic       i_pop,
    output t_pair_word o_head_word,
    output t_q_status  o_status
);

    t_pair_word          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wptr;
    logic [Q_PTR_W-1:0]  r_rptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                do_pop;

    assign o_status.full     = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.nonempty = (r_count != '0);
    assign o_head_word       = r_mem[r_rptr];
    assign do_pop            = i_pop && o_status.nonempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/tppa_back.sv =====
// back end: gain multiply, shift, saturation and running total per pair
// depends on tppa_pkg; output register drives the result channel
`timescale 1ns / 1ps

module tppa_back
    import tppa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_pair_word             i_head_word,
    input  t_q_status              i_q_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [IDX_W-1:0]       o_pair_index,
    output logic [RAW_W-1:0]       o_raw_difference,
    output logic [OUT_W-1:0]       o_scaled_difference,
    output logic [OUT_W-1:0]       o_scaled_total
);

    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    function automatic logic [OUT_W-1:0] sat_add(input logic [OUT_W-1:0] x,
                                                 input logic [OUT_W-1:0] y);
        logic [OUT_W-1:0] r;
        r = x + y;
        if ((x[OUT_W-1] == y[OUT_W-1]) && (r[OUT_W-1] != x[OUT_W-1])) begin
            r = x[OUT_W-1] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

    // per-stage valids and ready chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_vout;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

    // common payload carried down the stages
    logic [IDX_W-1:0]         r1_idx, r2_idx, r3_idx, r4_idx, r5_idx, r6_idx;
    logic signed [DIFF_W-1:0] r1_diff, r2_diff, r3_diff, r4_diff, r5_diff, r6_diff;
    logic                     r1_neg, r2_neg, r3_neg, r4_neg, r5_neg;

    logic [MAG_W-1:0]         r1_mag;
    logic [HI_W-1:0]          r2_hi;
    logic [63:0]              r2_a, r3_a;
    logic [HI_W+GAIN_W-1:0]   r3_b;
    logic [PROD_W-1:0]        r4_prod;
    logic [PROD_W-1:0]        r5_q;
    logic                     r5_rem;
    logic [OUT_W-1:0]         r6_sc;
    logic [OUT_W-1:0]         r_total;

    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        rem_mask;
    logic [OUT_W:0]           neg_sum;
    logic [OUT_W-1:0]         sc;
    logic [OUT_W-1:0]         total_next;
    logic [OUT_W-1:0]         diff_ext;

    assign rdy_out = !r_vout || !i_out_stall;
    assign rdy6    = !r_v6 || rdy_out;
    assign rdy5    = !r_v5 || rdy6;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_pop   = rdy1 && i_q_status.nonempty;

    always_comb begin
        mag = i_head_word.diff[DIFF_W-1] ? MAG_W'(-i_head_word.diff)
                                         : MAG_W'(i_head_word.diff);
        rem_mask = ~({PROD_W{1'b1}} << i_cfg.shift);
        neg_sum  = {1'b0, r5_q[OUT_W-1:0]} + (OUT_W+1)'(r5_rem);
        if (|r5_q[PROD_W-1:OUT_W-1]) begin
            sc = r5_neg ? SAT_MIN : SAT_MAX;
        end else begin
            sc = r5_neg ? OUT_W'(-neg_sum) : r5_q[OUT_W-1:0];
        end
        total_next = sat_add(r_total, r6_sc);
        diff_ext   = OUT_W'(r6_diff);
    end

    // valid bits and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
            r_vout  <= 1'b0;
            r_total <= '0;
        end else begin
            if (rdy1)    r_v1   <= i_q_status.nonempty;
            if (rdy2)    r_v2   <= r_v1;
            if (rdy3)    r_v3   <= r_v2;
            if (rdy4)    r_v4   <= r_v3;
            if (rdy5)    r_v5   <= r_v4;
            if (rdy6)    r_v6   <= r_v5;
            if (rdy_out) r_vout <= r_v6;
            if (rdy_out && r_v6) begin
                r_total <= total_next;
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_idx  <= i_head_word.idx;
            r1_diff <= i_head_word.diff;
            r1_neg  <= i_head_word.diff[DIFF_W-1];
            r1_mag  <= mag;
        end
        if (rdy2) begin
            r2_idx  <= r1_idx;
            r2_diff <= r1_diff;
            r2_neg  <= r1_neg;
            r2_hi   <= r1_mag[MAG_W-1:32];
            r2_a    <= 64'(r1_mag[31:0]) * 64'(i_cfg.gain);
        end
        if (rdy3) begin
            r3_idx  <= r2_idx;
            r3_diff <= r2_diff;
            r3_neg  <= r2_neg;
            r3_a    <= r2_a;
            r3_b    <= (HI_W+GAIN_W)'(r2_hi) * (HI_W+GAIN_W)'(i_cfg.gain);
        end
        if (rdy4) begin
            r4_idx  <= r3_idx;
            r4_diff <= r3_diff;
            r4_neg  <= r3_neg;
            r4_prod <= PROD_W'(r3_a) + {r3_b, 32'd0};
        end
        if (rdy5) begin
            r5_idx  <= r4_idx;
            r5_diff <= r4_diff;
            r5_neg  <= r4_neg;
            r5_q    <= r4_prod >> i_cfg.shift;
            r5_rem  <= |(r4_prod & rem_mask);
        end
        if (rdy6) begin
            r6_idx  <= r5_idx;
            r6_diff <= r5_diff;
            r6_sc   <= sc;
        end
        if (rdy_out) begin
            o_pair_index        <= r6_idx;
            o_raw_difference    <= diff_ext[RAW_W-1:0];
            o_scaled_difference <= r6_sc;
            o_scaled_total      <= total_next;
        end
    end

    assign o_out_valid = r_vout;

endmodule

// ===== rtl/triggered_pulse_pair_asymmetry_core.sv =====
// top level of the triggered pulse pair asymmetry core
// depends on tppa_pkg, tppa_front, tppa_fifo, tppa_back and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   direction  handshake                word
// ---------------------------------------------------------------------------
// in        sink       i_in_valid / o_in_stall  trigger sample, signal sample
// out       source     o_out_valid / i_out_stall pair index, raw, scaled, total
// cfg       sink       i_cfg_valid / o_cfg_ready register index, write data
//
// one input word is taken every cycle while o_in_stall is low; the front updates
// its counters and integrator once per accepted word
// a completed pair crosses a four entry queue and then seven register
// stages of gain multiply, shift, saturation and running total, the last
// of which drives o_out_valid
// o_in_stall rises only while the pair queue is full, so output stalls
// reach the input after the back pipeline and the queue have filled
// reset is synchronous and active low; configuration returns to its
// defaults and there is no clearing pass

module triggered_pulse_pair_asymmetry_core
    import tppa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [IN_W-1:0]       i_trigger_sample,
    input  logic [IN_W-1:0]       i_signal_sample,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_pair_index,
    output logic [RAW_W-1:0]      o_raw_difference,
    output logic [OUT_W-1:0]      o_scaled_difference,
    output logic [OUT_W-1:0]      o_scaled_total,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       in_accept;
    logic       push;
    t_pair_word push_word;
    t_pair_word head_word;
    t_q_status  q_status;
    logic       pop;

    // terms watched by the checks below
    logic       push_full;
    logic       zero_out;
    logic       nonzero_out;
    logic       scaled_zero;
    logic       sign_ok;

    // configuration registers are always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.delay     <= RST_DELAY;
            r_cfg.length    <= RST_LENGTH;
            r_cfg.gain      <= RST_GAIN;
            r_cfg.shift     <= RST_SHIFT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data[THR_W-1:0];
                CFG_DELAY:     r_cfg.delay     <= i_cfg_data[WIN_W-1:0];
                CFG_LENGTH:    r_cfg.length    <= i_cfg_data[WIN_W-1:0];
                CFG_GAIN:      r_cfg.gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_SHIFT:     r_cfg.shift     <= i_cfg_data[SHF_W-1:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // each word can finish at most one pair, so one free queue slot suffices
    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    tppa_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_accept         (in_accept),
        .i_trigger_sample (i_trigger_sample),
        .i_signal_sample  (i_signal_sample),
        .o_push           (push),
        .o_push_word      (push_word)
    );

    tppa_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .i_pop       (pop),
        .o_head_word (head_word),
        .o_status    (q_status)
    );

    tppa_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_head_word         (head_word),
        .i_q_status          (q_status),
        .o_pop               (pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_pair_index        (o_pair_index),
        .o_raw_difference    (o_raw_difference),
        .o_scaled_difference (o_scaled_difference),
        .o_scaled_total      (o_scaled_total)
    );

    assign push_full   = push && q_status.full;
    assign zero_out    = o_out_valid && (o_raw_difference == '0);
    assign nonzero_out = o_out_valid && (o_raw_difference != '0);
    assign scaled_zero = (o_scaled_difference == '0);
    assign sign_ok     = o_raw_difference[RAW_W-1] ? (o_scaled_difference[OUT_W-1] || scaled_zero)
                                                   : !o_scaled_difference[OUT_W-1];

    // a finished pair must always find room in the queue
    `ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, push_full, "push into full queue")

    // zero difference scales to zero whatever the gain
    `ASSERT_IMPLIES(a_zero_scales_zero, i_clk, i_rst_n, zero_out, scaled_zero, "nonzero from zero")

    // scaling never flips the sign of the difference
    `ASSERT_IMPLIES(a_sign_kept, i_clk, i_rst_n, nonzero_out, sign_ok, "wrong scaled sign")

endmodule

// ===== tb/triggered_pulse_pair_asymmetry_core_tb.sv =====
// self-checking bench for the triggered pulse pair asymmetry core
// drives trigger and signal words, predicts each pulse pair result in-bench and
// compares field by field; depends on tppa_pkg and triggered_pulse_pair_asymmetry_core
`timescale 1ns / 1ps

module triggered_pulse_pair_asymmetry_core_tb;
    import tppa_pkg::*;

    // run limits: generous wall, bounded drain, and a tail that covers the
    // four entry pair queue plus the seven stage scaling pipeline
    localparam int unsigned RUN_LIMIT_NS = 20_000_000;
    localparam int unsigned DRAIN_LIMIT  = 20_000;
    localparam int unsigned PIPE_TAIL    = 40;

    // one completed pulse pair as seen on the output port
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [RAW_W-1:0] raw;
        logic [OUT_W-1:0] scaled;
        logic [OUT_W-1:0] total;
    } pair_result_t;

    // directed stimulus row; typed rows carry their expected pair result
    typedef struct packed {
        logic [IN_W-1:0] trig;
        logic [IN_W-1:0] sig;
        logic            typed;
        pair_result_t    pair;
    } probe_row_t;

    localparam pair_result_t NO_PAIR = '0;

    // directed rows run with threshold 1000, no delay and a one sample window,
    // so every firing word is a whole pulse and every second one closes a pair
    localparam int N_PROBES = 15;
    localparam probe_row_t PROBE_ROWS [N_PROBES] = '{
        '{32'd0,          32'd5,          1'b0, NO_PAIR},
        // magnitude equal to the threshold must not fire, either sign
        '{32'd1000,       32'd7,          1'b0, NO_PAIR},
        '{-32'sd1000,     32'd9,          1'b0, NO_PAIR},
        // largest positive minus most negative sample
        '{32'd1001,       32'h7FFF_FFFF,  1'b0, NO_PAIR},
        '{32'h8000_0000,  32'h8000_0000,  1'b1,
            '{20'd0, 43'h0_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF}},
        '{-32'sd1001,     32'd0,          1'b0, NO_PAIR},
        '{32'h7FFF_FFFF,  32'h7FFF_FFFF,  1'b1,
            '{20'd1, 43'h7FF_8000_0001, 64'hFFFF_FFFF_8000_0001, 64'h0000_0000_8000_0000}},
        '{32'd0,          32'hFFFF_FFFF,  1'b0, NO_PAIR},
        '{32'd5000,       32'hFFFF_FFFF,  1'b0, NO_PAIR},
        '{-32'sd5000,     32'd1,          1'b1,
            '{20'd2, 43'h7FF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0000_0000_7FFF_FFFE}},
        '{32'd5000,       32'hAAAA_AAAA,  1'b0, NO_PAIR},
        '{-32'sd5000,     32'h5555_5555,  1'b0, NO_PAIR},
        '{32'd1001,       32'd1,          1'b0, NO_PAIR},
        '{32'h7FFF_FFFF,  32'hFFFF_FFFF,  1'b0, NO_PAIR},
        '{32'd1,          32'd12345,      1'b0, NO_PAIR}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [IN_W-1:0]       i_trigger_sample;
    logic [IN_W-1:0]       i_signal_sample;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [IDX_W-1:0]      o_pair_index;
    logic [RAW_W-1:0]      o_raw_difference;
    logic [OUT_W-1:0]      o_scaled_difference;
    logic [OUT_W-1:0]      o_scaled_total;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    triggered_pulse_pair_asymmetry_core u_dut (.*);

    // bench copy of the register file
    logic [THR_W-1:0]  cfg_thr;
    logic [WIN_W-1:0]  cfg_delay;
    logic [WIN_W-1:0]  cfg_len;
    logic [GAIN_W-1:0] cfg_gain;
    logic [SHF_W-1:0]  cfg_shift;

    // bench copy of the trigger, delay and integrator state
    logic [9:0]         holdoff_left;
    logic [10:0]        delay_left;
    logic [9:0]         window_left;
    logic signed [63:0] pulse_sum;
    logic signed [63:0] even_sum;
    logic               odd_pulse;
    logic [IDX_W-1:0]   pairs_done;
    logic [OUT_W-1:0]   running_total;

    pair_result_t expected_pairs[$];
    pair_result_t head_pair;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int words_sent;
    int pairs_checked;
    int settings_run;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // wall clock guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // receiver back-pressure, decided afresh every cycle
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [32:0] trig_mag(input logic [31:0] t);
        return t[31] ? (33'd0 - {1'b1, t}) : {1'b0, t};
    endfunction

    // zero length is taken as one; ten bits cannot exceed the maximum window
    function automatic logic [9:0] window_width();
        return (cfg_len == '0) ? 10'd1 : cfg_len;
    endfunction

    // floor of diff times gain over two to the shift, clamped to 64 bits
    function automatic logic [63:0] scale_diff(input logic signed [63:0] d);
        logic signed [127:0] dx;
        logic signed [127:0] gx;
        logic signed [127:0] q;
        logic signed [127:0] hi_lim;
        dx = d;
        gx = {96'd0, cfg_gain};
        hi_lim = {65'd0, {63{1'b1}}};
        q = (dx * gx) >>> cfg_shift;
        if (q > hi_lim)
            return hi_lim[63:0];
        if (q < ~hi_lim)
            return ~hi_lim[63:0];
        return q[63:0];
    endfunction

    function automatic logic [63:0] clamp_add(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63])
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    // one sample tick of the trigger search, delay and boxcar; a pending delay
    // that runs out starts its window before a fresh trigger is considered
    task automatic advance_integrator(input logic [31:0] trig, input logic [31:0] sig,
                                      output bit produced, output pair_result_t res);
        logic [9:0]         width;
        logic [10:0]        lag;
        logic signed [63:0] diff;
        logic [63:0]        scaled;
        produced = 1'b0;
        res = '0;
        width = window_width();
        if (delay_left != 0) begin
            delay_left = delay_left - 1'b1;
            if (delay_left == 0) begin
                pulse_sum = 0;
                window_left = width;
            end
        end
        if (holdoff_left != 0) begin
            holdoff_left = holdoff_left - 1'b1;
        end else if (trig_mag(trig) > {2'b00, cfg_thr}) begin
            // delay never longer than the window
            lag = (cfg_delay < width) ? {1'b0, cfg_delay} : {1'b0, width};
            holdoff_left = width - 1'b1;
            if (lag == 0) begin
                // restarts any window still running
                pulse_sum = 0;
                window_left = width;
            end else begin
                delay_left = lag;
            end
        end
        if (window_left != 0) begin
            pulse_sum = pulse_sum + $signed(sig);
            window_left = window_left - 1'b1;
            if (window_left == 0) begin
                if (!odd_pulse) begin
                    even_sum = pulse_sum;
                    odd_pulse = 1'b1;
                end else begin
                    diff = even_sum - pulse_sum;
                    scaled = scale_diff(diff);
                    running_total = clamp_add(running_total, scaled);
                    res.idx = pairs_done;
                    res.raw = diff[RAW_W-1:0];
                    res.scaled = scaled;
                    res.total = running_total;
                    pairs_done = pairs_done + 1'b1;
                    odd_pulse = 1'b0;
                    produced = 1'b1;
                end
            end
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_THRESHOLD: cfg_thr   = val[THR_W-1:0];
            CFG_DELAY:     cfg_delay = val[WIN_W-1:0];
            CFG_LENGTH:    cfg_len   = val[WIN_W-1:0];
            CFG_GAIN:      cfg_gain  = val[GAIN_W-1:0];
            CFG_SHIFT:     cfg_shift = val[SHF_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // valid stays high across back-to-back words; gaps are drawn per word
    task automatic push_word(input logic [31:0] trig, input logic [31:0] sig,
                             input bit typed, input pair_result_t typed_pair);
        bit           produced;
        pair_result_t res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_trigger_sample <= trig;
        i_signal_sample  <= sig;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        advance_integrator(trig, sig, produced, res);
        if (typed)
            expected_pairs.push_back(typed_pair);
        else if (produced)
            expected_pairs.push_back(res);
    endtask

    // stop sending and let every outstanding pair come out, then the tail
    task automatic drain_pairs();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_pairs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_pairs.size() != 0) begin
            mismatch_count++;
            $display("%0t ns: expected %0d more pair words, got none", $time,
                     expected_pairs.size());
            expected_pairs.delete();
        end
        repeat (PIPE_TAIL) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_trigger(input int fire_pct);
        logic [31:0] t;
        if ($urandom_range(99) < fire_pct) begin
            // only the most negative sample beats the top threshold
            if (cfg_thr == '1)
                return 32'h8000_0000;
            t = $urandom;
            while (trig_mag(t) <= {2'b00, cfg_thr})
                t = $urandom;
            return t;
        end
        t = $urandom_range(cfg_thr);
        return $urandom_range(1) ? -t : t;
    endfunction

    function automatic logic [31:0] pick_signal();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(200) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input logic [30:0] thr, input logic [9:0] dly,
                             input logic [9:0] len, input logic [31:0] gain,
                             input logic [5:0] shf, input int idle_pct, input int stall_pct,
                             input int n_words, input int fire_pct, input int pause_at);
        drain_pairs();
        write_reg(CFG_THRESHOLD, {1'b0, thr});
        write_reg(CFG_DELAY, {22'd0, dly});
        write_reg(CFG_LENGTH, {22'd0, len});
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_SHIFT, {26'd0, shf});
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        settings_run++;
        for (int k = 0; k < n_words; k++) begin
            // hold off until the block has handed back everything owed
            if (k == pause_at)
                drain_pairs();
            push_word(pick_trigger(fire_pct), pick_signal(), 1'b0, NO_PAIR);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    // output side: every accepted pair word is matched against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pairs.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: expected no pair word, got index %h raw %h", $time,
                         o_pair_index, o_raw_difference);
            end else begin
                head_pair = expected_pairs.pop_front();
                pairs_checked++;
                check_field("pair_index", 64'(head_pair.idx), 64'(o_pair_index));
                check_field("raw_difference", 64'(head_pair.raw), 64'(o_raw_difference));
                check_field("scaled_difference", head_pair.scaled, o_scaled_difference);
                check_field("scaled_total", head_pair.total, o_scaled_total);
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_trigger_sample = '0;
        i_signal_sample  = '0;
        i_out_stall      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_THRESHOLD;
        i_cfg_data       = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        mismatch_count   = 0;
        words_sent       = 0;
        pairs_checked    = 0;
        settings_run     = 1;

        // register defaults and cleared state, as after reset
        cfg_thr       = RST_THRESHOLD;
        cfg_delay     = RST_DELAY;
        cfg_len       = RST_LENGTH;
        cfg_gain      = RST_GAIN;
        cfg_shift     = RST_SHIFT;
        holdoff_left  = '0;
        delay_left    = '0;
        window_left   = '0;
        pulse_sum     = '0;
        even_sum      = '0;
        odd_pulse     = 1'b0;
        pairs_done    = '0;
        running_total = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: single sample pulses, unit gain
        write_reg(CFG_THRESHOLD, 32'd1000);
        write_reg(CFG_DELAY, 32'd0);
        write_reg(CFG_LENGTH, 32'd1);
        write_reg(CFG_GAIN, 32'd1);
        write_reg(CFG_SHIFT, 32'd0);
        for (int r = 0; r < N_PROBES; r++)
            push_word(PROBE_ROWS[r].trig, PROBE_ROWS[r].sig, PROBE_ROWS[r].typed,
                      PROBE_ROWS[r].pair);

        // short delayed windows, no idling
        run_phase(31'd1000, 10'd3, 10'd8, 32'd3, 6'd1, 0, 0, 120, 20, -1);
        // zero threshold, zero length taken as one, full gain: saturation
        run_phase(31'd0, 10'd0, 10'd0, 32'hFFFF_FFFF, 6'd0, 73, 0, 100, 50, -1);
        // top threshold, delay clamped to the window, widest shift
        run_phase(31'h7FFF_FFFF, 10'd1023, 10'd5, 32'd7, 6'd63, 0, 73, 120, 30, -1);
        // random gain and shift, both sides idling, with a full pause midway
        run_phase(31'd12345, 10'd2, 10'd16, $urandom, 6'($urandom_range(63)),
                  27, 27, 150, 25, 75);
        // widest window; the run ends inside a second pulse
        run_phase(31'd95_000_000, 10'd0, 10'd1023, 32'd1, 6'd0, 0, 0, 1100, 40, -1);
        // short windows cut the unfinished wide sum; zero gain
        run_phase(31'd1, 10'd1, 10'd2, 32'd0, 6'd32, 27, 27, 100, 40, -1);
        // delay past the window again, random scaling, sender gaps
        run_phase(31'd500, 10'd7, 10'd3, $urandom, 6'($urandom_range(63)),
                  73, 0, 100, 30, -1);

        drain_pairs();

        $display("covered %0d input words over %0d register settings, %0d pairs checked",
                 words_sent, settings_run, pairs_checked);
        $display("threshold, delay and window extremes with sender gaps and output stalls");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tppa_pkg.sv
rtl/tppa_front.sv
rtl/tppa_fifo.sv
rtl/tppa_back.sv
rtl/triggered_pulse_pair_asymmetry_core.sv
tb/triggered_pulse_pair_asymmetry_core_tb.sv
